// ----- src/calendar_time_advance_unit_defines.svh -----
`ifndef CALENDAR_TIME_ADVANCE_UNIT_DEFINES_SVH
`define CALENDAR_TIME_ADVANCE_UNIT_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define CTAU_ASSERT_NOW(lbl, clk, rst_n, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error(msg);

// The condition must hold in the cycle after the trigger.
`define CTAU_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ----- src/ctau_pkg.sv -----
`default_nettype none

package ctau_pkg;

	localparam int unsigned SEC_W   = 6;
	localparam int unsigned MIN_W   = 6;
	localparam int unsigned HOUR_W  = 5;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 7;

	localparam int unsigned FIELDS_W = SEC_W + MIN_W + HOUR_W + DAY_W + MONTH_W + YEAR_W;
	localparam int unsigned TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

	localparam logic [SEC_W-1:0]   SEC_TOP   = 6'd59;
	localparam logic [MIN_W-1:0]   MIN_TOP   = 6'd59;
	localparam logic [HOUR_W-1:0]  HOUR_TOP  = 5'd23;
	localparam logic [MONTH_W-1:0] MONTH_TOP = 4'd12;
	localparam logic [YEAR_W-1:0]  YEAR_TOP  = 7'd99;
	localparam logic [SEC_W-1:0]   STEP_RST  = 6'd5;

	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [DAY_W-1:0]   FEB_LEAP  = 5'd29;

	// Register index taken from paddr[2].
	localparam logic REG_STEP = 1'b0;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	typedef struct packed {
		logic en;
		logic load;
		logic carry;
	} cell_ctrl_t;

	// Last field (second) in the lowest bits, year in the highest.
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [SEC_W-1:0]   second;
	} time_t;

	function automatic logic [DAY_W-1:0] month_days(
		input logic [MONTH_W-1:0] month,
		input logic [YEAR_W-1:0]  year
	);
		logic [DAY_W-1:0] len;
		case (month)
			4'd2:    len = 5'd28;
			4'd4:    len = 5'd30;
			4'd6:    len = 5'd30;
			4'd9:    len = 5'd30;
			4'd11:   len = 5'd30;
			default: len = 5'd31;
		endcase
		if (month == MONTH_FEB && year[1:0] == 2'b00) begin
			len = FEB_LEAP;
		end
		return len;
	endfunction

endpackage

`default_nettype wire

// ----- src/ctau_cell.sv -----
`default_nettype none

module ctau_cell #(
	parameter int unsigned W       = 6,
	parameter int unsigned RST_VAL = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctau_pkg::cell_ctrl_t ctrl,
	input  logic [W-1:0]         load_val,
	input  logic [W-1:0]         inc,
	input  logic [W-1:0]         top,
	input  logic [W-1:0]         base,
	output logic [W-1:0]         value,
	output logic [W-1:0]         nxt,
	output logic                 carry_out
);

	logic [W-1:0] value_q;
	logic [W:0]   sum;
	logic [W:0]   far_lim;
	logic [W:0]   wrap_full;
	logic         over;
	logic [W-1:0] wrapped;

	assign sum       = {1'b0, value_q} + {1'b0, inc};
	assign far_lim   = {1'b0, top} + {1'b0, inc};
	assign wrap_full = sum - {1'b0, top} - (W+1)'(1) + {1'b0, base};
	assign over      = sum > {1'b0, top};

	// A value loaded above its limit (a long day in a short month) restarts at base.
	assign wrapped = (sum > far_lim) ? base : wrap_full[W-1:0];

	always_comb begin
		if (ctrl.load) begin
			nxt = load_val;
		end else if (ctrl.carry) begin
			nxt = over ? wrapped : sum[W-1:0];
		end else begin
			nxt = value_q;
		end
	end

	assign carry_out = ctrl.carry & ~ctrl.load & over;
	assign value     = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= W'(RST_VAL);
		end else if (ctrl.en) begin
			value_q <= nxt;
		end
	end

endmodule

`default_nettype wire

// ----- src/ctau_out_skid.sv -----
`default_nettype none

module ctau_out_skid (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ctau_pkg::time_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output ctau_pkg::time_t  out_data
);
	import ctau_pkg::*;

	logic  out_valid_q;
	logic  skid_valid_q;
	time_t out_data_q;
	time_t skid_data_q;
	logic  in_fire;
	logic  out_free;

	assign in_ready  = ~skid_valid_q;
	assign in_fire   = in_valid & ~skid_valid_q;
	assign out_free  = ~out_valid_q | out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q | in_fire;
			skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end else if (in_fire) begin
			skid_data_q <= in_data;
		end
	end

endmodule

`default_nettype wire

// ----- src/calendar_time_advance_unit.sv -----
// Calendar time unit: holds second, minute, hour, day, month and a two-digit year
// (2000 to 2099) and returns one beat with the new time for every input beat. A tick
// beat (tuser low) adds the step register to the seconds; a load beat (tuser high)
// stores the tdata fields after clamping each into its range. The unit takes one
// beat per cycle while the output buffer has room and registers each result there;
// the carry ripples through the six counter cells combinationally, and a two-entry
// output buffer lets the next beat enter while an earlier result waits on
// m_axis_tready. The step register (byte address 0) saturates at 59 and resets to 5.
`default_nettype none

module calendar_time_advance_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// second[5:0], minute[11:6], hour[16:12], day[21:17], month[25:22], year[32:26]
	input  logic [ctau_pkg::TDATA_W-1:0]    s_axis_tdata,
	// operation: 0 tick, 1 load
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// second[5:0], minute[11:6], hour[16:12], day[21:17], month[25:22], year[32:26]
	output logic [ctau_pkg::TDATA_W-1:0]    m_axis_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [2:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import ctau_pkg::*;

	logic             in_fire;
	logic             is_load;
	logic             tick;
	logic [SEC_W-1:0] step_q;
	logic [SEC_W-1:0] wr_step;
	time_t            ld;
	time_t            ld_clamped;
	time_t            cur;
	time_t            nxt;
	cell_ctrl_t       ctrl_sec;
	cell_ctrl_t       ctrl_min;
	cell_ctrl_t       ctrl_hour;
	cell_ctrl_t       ctrl_day;
	cell_ctrl_t       ctrl_month;
	cell_ctrl_t       ctrl_year;
	logic             c_sec;
	logic             c_min;
	logic             c_hour;
	logic             c_day;
	logic             c_month;
	logic             c_year;
	logic [DAY_W-1:0] day_top;

	// Configuration port.
	assign pready  = 1'b1;
	assign wr_step = (pwdata[SEC_W-1:0] > SEC_TOP) ? SEC_TOP : pwdata[SEC_W-1:0];
	assign prdata  = (paddr[2] == REG_STEP) ? {{(32-SEC_W){1'b0}}, step_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_STEP) begin
			step_q <= wr_step;
		end
	end

	// Load fields are clamped into range before they enter the cells.
	assign ld = time_t'(s_axis_tdata[FIELDS_W-1:0]);

	always_comb begin
		ld_clamped.second = (ld.second > SEC_TOP) ? SEC_TOP : ld.second;
		ld_clamped.minute = (ld.minute > MIN_TOP) ? MIN_TOP : ld.minute;
		ld_clamped.hour   = (ld.hour > HOUR_TOP) ? HOUR_TOP : ld.hour;
		ld_clamped.day    = (ld.day == '0) ? DAY_W'(1) : ld.day;
		if (ld.month == '0) begin
			ld_clamped.month = MONTH_W'(1);
		end else if (ld.month > MONTH_TOP) begin
			ld_clamped.month = MONTH_TOP;
		end else begin
			ld_clamped.month = ld.month;
		end
		ld_clamped.year   = (ld.year > YEAR_TOP) ? YEAR_TOP : ld.year;
	end

	assign in_fire = s_axis_tvalid & s_axis_tready;
	assign is_load = (s_axis_tuser == OP_LOAD);
	assign tick    = (s_axis_tuser == OP_TICK);

	// Month and year only move after a day carry, so the current values set the day limit.
	assign day_top = month_days(cur.month, cur.year);

	assign ctrl_sec   = '{en: in_fire, load: is_load, carry: tick};
	assign ctrl_min   = '{en: in_fire, load: is_load, carry: c_sec};
	assign ctrl_hour  = '{en: in_fire, load: is_load, carry: c_min};
	assign ctrl_day   = '{en: in_fire, load: is_load, carry: c_hour};
	assign ctrl_month = '{en: in_fire, load: is_load, carry: c_day};
	assign ctrl_year  = '{en: in_fire, load: is_load, carry: c_month};

	ctau_cell #(.W(SEC_W), .RST_VAL(0)) u_sec (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl_sec), .load_val(ld_clamped.second),
		.inc(step_q), .top(SEC_TOP), .base('0),
		.value(cur.second), .nxt(nxt.second), .carry_out(c_sec)
	);

	ctau_cell #(.W(MIN_W), .RST_VAL(0)) u_min (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl_min), .load_val(ld_clamped.minute),
		.inc(MIN_W'(1)), .top(MIN_TOP), .base('0),
		.value(cur.minute), .nxt(nxt.minute), .carry_out(c_min)
	);

	ctau_cell #(.W(HOUR_W), .RST_VAL(0)) u_hour (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl_hour), .load_val(ld_clamped.hour),
		.inc(HOUR_W'(1)), .top(HOUR_TOP), .base('0),
		.value(cur.hour), .nxt(nxt.hour), .carry_out(c_hour)
	);

	ctau_cell #(.W(DAY_W), .RST_VAL(1)) u_day (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl_day), .load_val(ld_clamped.day),
		.inc(DAY_W'(1)), .top(day_top), .base(DAY_W'(1)),
		.value(cur.day), .nxt(nxt.day), .carry_out(c_day)
	);

	ctau_cell #(.W(MONTH_W), .RST_VAL(1)) u_month (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl_month), .load_val(ld_clamped.month),
		.inc(MONTH_W'(1)), .top(MONTH_TOP), .base(MONTH_W'(1)),
		.value(cur.month), .nxt(nxt.month), .carry_out(c_month)
	);

	ctau_cell #(.W(YEAR_W), .RST_VAL(0)) u_year (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl_year), .load_val(ld_clamped.year),
		.inc(YEAR_W'(1)), .top(YEAR_TOP), .base('0),
		.value(cur.year), .nxt(nxt.year), .carry_out(c_year)
	);

	time_t out_time;

	ctau_out_skid u_out (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(nxt),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(out_time)
	);

	// The year carry has nowhere to go; it only marks the century wrap.
	assign m_axis_tdata = {{(TDATA_W-FIELDS_W){c_year & 1'b0}}, out_time};

endmodule

`default_nettype wire

// ----- src/ctau_checker.sv -----
`default_nettype none
`include "calendar_time_advance_unit_defines.svh"

module ctau_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tready,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [ctau_pkg::TDATA_W-1:0] m_axis_tdata,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [2:0]                   paddr,
	input logic [31:0]                  pwdata,
	input logic [31:0]                  prdata,
	input logic                         pready
);
	import ctau_pkg::*;

	time_t mt;
	assign mt = time_t'(m_axis_tdata[FIELDS_W-1:0]);

	`CTAU_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

	`CTAU_ASSERT_NOW(a_full_has_out, clk, arst_n, !s_axis_tready,
		m_axis_tvalid, "input stalled with no result pending")

	`CTAU_ASSERT_NOW(a_out_range, clk, arst_n, m_axis_tvalid,
		mt.second <= SEC_TOP && mt.minute <= MIN_TOP && mt.hour <= HOUR_TOP
			&& mt.day != '0 && mt.month != '0 && mt.month <= MONTH_TOP
			&& mt.year <= YEAR_TOP,
		"result field out of range")

	`CTAU_ASSERT_NOW(a_step_range, clk, arst_n, psel && !pwrite && paddr[2] == REG_STEP,
		prdata <= 32'd59, "step register outside its range")

	`CTAU_ASSERT_NEXT(a_step_write, clk, arst_n,
		psel && penable && pwrite && pready && paddr[2] == REG_STEP
			&& pwdata[SEC_W-1:0] <= SEC_TOP,
		prdata[SEC_W-1:0] == $past(pwdata[SEC_W-1:0]) || paddr[2] != REG_STEP,
		"step register write lost")

endmodule

bind calendar_time_advance_unit ctau_checker u_ctau_checker (.*);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import ctau_pkg::*;

	localparam int unsigned TIME_W      = $bits(time_t);
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam logic [2:0]  STEP_ADDR   = {REG_STEP, 2'b00};
	localparam logic [2:0]  SPARE_ADDR  = {~REG_STEP, 2'b00};

	class calendar_scoreboard;
		time_t       now;
		logic [5:0]  step_sec;
		time_t       expected_q[$];
		int unsigned errors;
		int unsigned checked;
		int unsigned ticks;
		int unsigned loads;
		int unsigned day_rolls;
		int unsigned month_rolls;
		int unsigned year_rolls;
		int unsigned leap_days;

		function new();
			step_sec = STEP_RST;
			now = '0;
			now.day = 5'd1;
			now.month = 4'd1;
		endfunction

		static function int unsigned days_in_month(int unsigned mo, int unsigned yr);
			int unsigned len;
			case (mo)
				2:           len = (yr % 4 == 0) ? 29 : 28;
				4, 6, 9, 11: len = 30;
				default:     len = 31;
			endcase
			return len;
		endfunction

		function void write_reg(logic idx, logic [31:0] value);
			if (idx == REG_STEP) begin
				step_sec = (value[5:0] > 6'd59) ? 6'd59 : value[5:0];
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// Seconds carry into minutes, hours, days, months and years in turn.
		function void advance();
			int unsigned s;
			int unsigned d;
			s = now.second + step_sec;
			if (s < 60) begin
				now.second = 6'(s);
			end else begin
				now.second = 6'(s - 60);
				if (now.minute < 59) begin
					now.minute = now.minute + 6'd1;
				end else begin
					now.minute = '0;
					if (now.hour < 23) begin
						now.hour = now.hour + 5'd1;
					end else begin
						now.hour = '0;
						d = now.day + 1;
						if (d <= days_in_month(now.month, now.year)) begin
							now.day = 5'(d);
							if (d == 29 && now.month == MONTH_FEB) leap_days++;
						end else begin
							now.day = 5'd1;
							day_rolls++;
							if (now.month < 12) begin
								now.month = now.month + 4'd1;
							end else begin
								now.month = 4'd1;
								month_rolls++;
								now.year = (now.year >= 99) ? 7'd0 : now.year + 7'd1;
								year_rolls++;
							end
						end
					end
				end
			end
		endfunction

		function void note_input(logic op, time_t beat);
			if (op == OP_LOAD) begin
				now.second = (beat.second > 59) ? 6'd59 : beat.second;
				now.minute = (beat.minute > 59) ? 6'd59 : beat.minute;
				now.hour   = (beat.hour > 23) ? 5'd23 : beat.hour;
				now.day    = (beat.day == 0) ? 5'd1 : beat.day;
				now.month  = (beat.month == 0) ? 4'd1 : (beat.month > 12) ? 4'd12 : beat.month;
				now.year   = (beat.year > 99) ? 7'd99 : beat.year;
				loads++;
			end else begin
				advance();
				ticks++;
			end
			expected_q.push_back(now);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want != got) begin
				errors++;
				if (errors <= 100) begin
					$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
				end
			end
		endfunction

		function void check_result(logic [TDATA_W-1:0] data);
			time_t want;
			time_t got;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result beat %h arrived with nothing expected", $time, data);
			end else begin
				want = expected_q.pop_front();
				got = data[TIME_W-1:0];
				checked++;
				compare_field("second", 32'(want.second), 32'(got.second));
				compare_field("minute", 32'(want.minute), 32'(got.minute));
				compare_field("hour", 32'(want.hour), 32'(got.hour));
				compare_field("day", 32'(want.day), 32'(got.day));
				compare_field("month", 32'(want.month), 32'(got.month));
				compare_field("year", 32'(want.year), 32'(got.year));
				compare_field("tdata pad", 32'd0, 32'(data[TDATA_W-1:TIME_W]));
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	// second[5:0], minute[11:6], hour[16:12], day[21:17], month[25:22], year[32:26]
	logic [TDATA_W-1:0] s_axis_tdata = '0;
	// operation: 0 tick, 1 load
	logic               s_axis_tuser = 1'b0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	// second[5:0], minute[11:6], hour[16:12], day[21:17], month[25:22], year[32:26]
	logic [TDATA_W-1:0] m_axis_tdata;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	calendar_scoreboard sb = new();
	bit                 quiet = 1'b0;
	int unsigned        cycle_count = 0;
	int unsigned        beats_sent = 0;
	int unsigned        step_writes = 0;

	calendar_time_advance_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("calendar_time_advance_unit: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_result(m_axis_tdata);
		end
	end

	initial begin : result_sink
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 14);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	function automatic time_t make_time(int unsigned s, int unsigned mi, int unsigned h,
			int unsigned d, int unsigned mo, int unsigned y);
		time_t t;
		t.second = 6'(s);
		t.minute = 6'(mi);
		t.hour   = 5'(h);
		t.day    = 5'(d);
		t.month  = 4'(mo);
		t.year   = 7'(y);
		return t;
	endfunction

	// Any bit pattern at all, out-of-range values included.
	function automatic time_t noise_fields();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[TIME_W-1:0];
	endfunction

	task automatic send_beat(input logic op, input time_t beat);
		int unsigned gap;
		logic [TDATA_W-1:0] word;
		gap = quiet ? 0 : $urandom_range(0, 14);
		word = '0;
		word[TIME_W-1:0] = beat;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= word;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(op, beat);
		beats_sent++;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(addr[2], value);
		if (addr == STEP_ADDR) step_writes++;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Load a time close to a rollover at a random depth, then tick through it.
	task automatic rollover_run();
		int unsigned depth;
		int unsigned mo;
		int unsigned yr;
		int unsigned len;
		int unsigned back;
		int unsigned run;
		time_t t;
		depth = $urandom_range(0, 5);
		mo = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(1, 12);
		yr = $urandom_range(0, 99);
		len = calendar_scoreboard::days_in_month(mo, yr);
		t = make_time($urandom_range(0, 59), $urandom_range(0, 59), $urandom_range(0, 23),
			$urandom_range(1, len), mo, yr);
		if (depth >= 1) begin
			back = $urandom_range(0, 2 * sb.step_sec);
			t.second = (back > 59) ? 6'd0 : 6'(59 - back);
			t.minute = 6'd59;
		end
		if (depth >= 2) t.hour = 5'd23;
		if (depth >= 3) begin
			// Now and then a day past the end of its month.
			t.day = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(len, 31)) : 5'(len);
		end
		if (depth >= 4) begin
			t.month = 4'd12;
			t.day = 5'd31;
		end
		if (depth == 5) t.year = 7'd99;
		send_beat(OP_LOAD, t);
		run = $urandom_range(1, 12);
		repeat (run) send_beat(OP_TICK, noise_fields());
	endtask

	initial begin : stimulus
		logic [31:0] step_list[8];
		int unsigned phase;
		int unsigned target;
		int unsigned pick;
		int unsigned n;

		step_list = '{32'd59, 32'd1, 32'd0, 32'd0, 32'd63, 32'd60, 32'd30, 32'd0};
		step_list[3] = $urandom_range(2, 58);
		step_list[7] = $urandom_range(1, 63);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset state, field extremes, clamping and calendar corners.
		send_beat(OP_TICK, noise_fields());
		send_beat(OP_LOAD, make_time(59, 59, 23, 31, 12, 99));
		send_beat(OP_TICK, '0);
		send_beat(OP_LOAD, '1);
		send_beat(OP_LOAD, '0);
		send_beat(OP_LOAD, make_time(59, 59, 23, 28, 2, 4));
		send_beat(OP_TICK, '1);
		send_beat(OP_LOAD, make_time(59, 59, 23, 29, 2, 4));
		send_beat(OP_TICK, '0);
		send_beat(OP_LOAD, make_time(59, 59, 23, 28, 2, 5));
		send_beat(OP_TICK, '0);
		send_beat(OP_LOAD, make_time(59, 59, 23, 31, 4, 7));
		send_beat(OP_TICK, '0);
		send_beat(OP_LOAD, make_time(59, 59, 23, 31, 2, 3));
		send_beat(OP_TICK, '0);
		send_beat(OP_LOAD, make_time(55, 59, 23, 30, 6, 10));
		send_beat(OP_TICK, '0);
		send_beat(OP_LOAD, make_time(58, 59, 23, 31, 12, 50));
		send_beat(OP_TICK, '0);
		send_beat(OP_LOAD, make_time(60, 60, 24, 0, 13, 100));
		send_beat(OP_LOAD, make_time(0, 0, 0, 0, 0, 0));
		wait_idle();

		write_reg(STEP_ADDR, 32'd0);
		send_beat(OP_TICK, '0);
		send_beat(OP_TICK, '1);
		wait_idle();
		write_reg(STEP_ADDR, 32'd63);
		send_beat(OP_TICK, '0);
		wait_idle();
		write_reg(SPARE_ADDR, 32'd1);
		send_beat(OP_TICK, '0);
		wait_idle();
		write_reg(STEP_ADDR, 32'hFFFF_FFC1);
		send_beat(OP_TICK, '0);
		wait_idle();

		// Random phases, each under its own step and with or without idling.
		for (phase = 0; phase < 8; phase++) begin
			quiet = (phase % 3 == 1);
			if (phase % 2 == 1) begin
				write_reg(STEP_ADDR, step_list[phase] | ($urandom & 32'hFFFF_FFC0));
			end else begin
				write_reg(STEP_ADDR, step_list[phase]);
			end
			write_reg(SPARE_ADDR, $urandom);
			target = beats_sent + 210;
			while (beats_sent < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					rollover_run();
				end else if (pick < 85) begin
					send_beat(OP_LOAD, noise_fields());
				end else begin
					n = $urandom_range(1, 4);
					repeat (n) send_beat(OP_TICK, noise_fields());
				end
			end
			wait_idle();
		end

		quiet = 1'b0;
		repeat (8) @(posedge clk);
		$display("Sent %0d beats (%0d ticks, %0d loads) under %0d step settings.",
			beats_sent, sb.ticks, sb.loads, step_writes);
		$display("Checked %0d results; saw %0d day, %0d month, %0d year rollovers, %0d leap days.",
			sb.checked, sb.day_rolls, sb.month_rolls, sb.year_rolls, sb.leap_days);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("calendar_time_advance_unit: match");
		end else begin
			$display("calendar_time_advance_unit: mismatch");
		end
		$finish;
	end

endmodule
